>>> src/gated_pid_angle_controller_macros.svh
// assertion macros used by the port-level checker
`ifndef GATED_PID_ANGLE_CONTROLLER_MACROS_SVH
`define GATED_PID_ANGLE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define GPAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gpac_pkg.sv
// types, constants and microprogram of the gated pid angle controller
package gpac_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [2:0] REG_GAIN_PROP    = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEG   = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV   = 3'd2;
  localparam logic [2:0] REG_TARGET_ANGLE = 3'd3;
  localparam logic [2:0] REG_STEP_TIME    = 3'd4;
  localparam logic [2:0] REG_STEP_RATE    = 3'd5;
  localparam logic [2:0] REG_GATE_LIMIT   = 3'd6;

  localparam logic signed [15:0] RST_GAIN_PROP    = 16'sd26;
  localparam logic signed [15:0] RST_GAIN_INTEG   = 16'sd256;
  localparam logic signed [15:0] RST_GAIN_DERIV   = 16'sd3;
  localparam logic signed [14:0] RST_TARGET_ANGLE = 15'sd0;
  localparam logic [15:0]        RST_STEP_TIME    = 16'd1092;
  localparam logic [15:0]        RST_STEP_RATE    = 16'd60;
  localparam logic [13:0]        RST_GATE_LIMIT   = 14'd5147;

  localparam logic signed [16:0] ANG_PI     = 17'sd12868;
  localparam logic signed [16:0] ANG_TWO_PI = 17'sd25736;

  localparam int unsigned MulAW = 18;
  localparam int unsigned MulBW = 35;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned AccW  = ProdW + 1;

  localparam logic [3:0] ST_IT   = 4'd0;
  localparam logic [3:0] ST_DR   = 4'd1;
  localparam logic [3:0] ST_KP   = 4'd2;
  localparam logic [3:0] ST_KI   = 4'd3;
  localparam logic [3:0] ST_KD   = 4'd4;
  localparam logic [3:0] ST_ACC  = 4'd5;
  localparam logic [3:0] ST_DRV  = 4'd6;
  localparam logic [3:0] ST_POS  = 4'd7;
  localparam logic [3:0] ST_SKIP = 4'd8;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_IT,
    MUL_DR,
    MUL_KP,
    MUL_KI,
    MUL_KD
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic {
    JMP_NONE,
    JMP_SKIP
  } jmp_e;

  typedef struct packed {
    mul_sel_e   mul_sel;
    acc_op_e    acc_op;
    logic       wr_integ;
    logic       wr_deriv;
    logic       wr_last;
    logic       wr_last_pre;
    logic       wr_drive;
    logic       wr_pos;
    logic       done;
    logic       applied;
    jmp_e       jmp;
    logic [3:0] target;
  } ctl_t;

  typedef struct packed {
    logic load;
    logic run;
    ctl_t cw;
  } dp_ctl_t;

  typedef struct packed {
    logic signed [15:0] gain_prop;
    logic signed [15:0] gain_integ;
    logic signed [15:0] gain_deriv;
    logic signed [14:0] target_angle;
    logic [15:0]        step_time;
    logic [15:0]        step_rate;
    logic [13:0]        gate_limit;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] angle;
  } in_beat_t;

  typedef struct packed {
    logic signed [23:0] drive;
    logic               applied;
    logic signed [31:0] cart_position;
    logic               saturated;
  } out_beat_t;

  typedef struct packed {
    logic signed [23:0] drive;
    logic signed [31:0] pos_sum;
    logic signed [31:0] pos_cur;
    logic               sat;
  } dp_res_t;

  function automatic ctl_t prog_word(input logic [3:0] step);
    ctl_t w;
    w = '0;
    case (step)
      ST_IT: begin
        w.mul_sel = MUL_IT;
        w.jmp     = JMP_SKIP;
        w.target  = ST_SKIP;
      end
      ST_DR: begin
        w.mul_sel  = MUL_DR;
        w.wr_integ = 1'b1;
      end
      ST_KP: begin
        w.mul_sel  = MUL_KP;
        w.wr_deriv = 1'b1;
        w.wr_last  = 1'b1;
      end
      ST_KI: begin
        w.mul_sel = MUL_KI;
        w.acc_op  = ACC_LOAD;
      end
      ST_KD: begin
        w.mul_sel = MUL_KD;
        w.acc_op  = ACC_ADD;
      end
      ST_ACC: begin
        w.acc_op = ACC_ADD;
      end
      ST_DRV: begin
        w.wr_drive = 1'b1;
      end
      ST_POS: begin
        w.wr_pos  = 1'b1;
        w.done    = 1'b1;
        w.applied = 1'b1;
      end
      ST_SKIP: begin
        w.wr_last_pre = 1'b1;
        w.done        = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

>>> src/gpac_dp.sv
// datapath: angle wrap, shared multiplier, accumulators and saturation
module gpac_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gpac_pkg::cfg_t    cfg_i,
  input  gpac_pkg::in_beat_t in_data_i,
  input  gpac_pkg::dp_ctl_t ctl_i,
  output logic              skip_o,
  output gpac_pkg::dp_res_t res_o
);
  import gpac_pkg::*;

  logic signed [16:0] ang_x;
  logic signed [16:0] theta_x;
  logic signed [16:0] mag_x;
  logic signed [16:0] err_d;
  logic [13:0]        mag;
  logic               gate_ok;

  logic signed [16:0] err_q;
  logic signed [16:0] last_q;
  logic               pre_q;
  logic               skip_q;
  logic signed [31:0] integ_q;
  logic signed [33:0] deriv_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] prod_d;
  logic signed [AccW-1:0]  acc_q;
  logic signed [23:0] drive_q;
  logic signed [31:0] pos_q;
  logic               sat_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulAW-1:0] diff;

  logic signed [ProdW-1:0] irnd_t;
  logic signed [18:0]      irnd;
  logic signed [32:0]      isum;
  logic signed [31:0]      integ_d;
  logic                    integ_clip;

  logic signed [AccW-1:0]  drnd_t;
  logic signed [AccW-9:0]  drnd;
  logic signed [23:0]      drive_d;
  logic                    drive_clip;

  logic signed [32:0]      psum;
  logic signed [31:0]      pos_d;
  logic                    pos_clip;

  ctl_t cw;
  logic run;

  assign cw  = ctl_i.cw;
  assign run = ctl_i.run;

  // wrap into [-pi, pi] with one correction
  always_comb begin
    ang_x = 17'(in_data_i.angle);
    if (ang_x > ANG_PI) begin
      theta_x = ang_x - ANG_TWO_PI;
    end else if (ang_x < -ANG_PI) begin
      theta_x = ang_x + ANG_TWO_PI;
    end else begin
      theta_x = ang_x;
    end
    mag_x   = theta_x[16] ? -theta_x : theta_x;
    mag     = mag_x[13:0];
    gate_ok = (mag < cfg_i.gate_limit);
    err_d   = 17'(cfg_i.target_angle) - theta_x;
  end

  assign diff = 18'(err_q) - 18'(last_q);

  always_comb begin
    case (cw.mul_sel)
      MUL_IT: begin
        mul_a = 18'(err_q);
        mul_b = $signed({19'd0, cfg_i.step_time});
      end
      MUL_DR: begin
        mul_a = diff;
        mul_b = $signed({19'd0, cfg_i.step_rate});
      end
      MUL_KP: begin
        mul_a = 18'(cfg_i.gain_prop);
        mul_b = 35'(err_q);
      end
      MUL_KI: begin
        mul_a = 18'(cfg_i.gain_integ);
        mul_b = 35'(integ_q);
      end
      MUL_KD: begin
        mul_a = 18'(cfg_i.gain_deriv);
        mul_b = 35'(deriv_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // integral update with round half up and clip
  always_comb begin
    irnd_t     = prod_q + 53'sd32768;
    irnd       = irnd_t[34:16];
    isum       = 33'(integ_q) + 33'(irnd);
    integ_clip = (isum[32] != isum[31]);
    if (!integ_clip) begin
      integ_d = isum[31:0];
    end else if (isum[32]) begin
      integ_d = 32'sh8000_0000;
    end else begin
      integ_d = 32'sh7fff_ffff;
    end
  end

  // drive from the weighted sum
  always_comb begin
    drnd_t = acc_q + 54'sd128;
    drnd   = drnd_t[AccW-1:8];
    if (drnd > 46'sd8388607) begin
      drive_d    = 24'sh7f_ffff;
      drive_clip = 1'b1;
    end else if (drnd < -46'sd8388608) begin
      drive_d    = 24'sh80_0000;
      drive_clip = 1'b1;
    end else begin
      drive_d    = drnd[23:0];
      drive_clip = 1'b0;
    end
  end

  always_comb begin
    psum     = 33'(pos_q) + 33'(drive_q);
    pos_clip = (psum[32] != psum[31]);
    if (!pos_clip) begin
      pos_d = psum[31:0];
    end else if (psum[32]) begin
      pos_d = 32'sh8000_0000;
    end else begin
      pos_d = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
      pos_q   <= '0;
      sat_q   <= 1'b0;
      skip_q  <= 1'b0;
      pre_q   <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        sat_q  <= 1'b0;
        skip_q <= !in_data_i.mode || !gate_ok;
        pre_q  <= !in_data_i.mode;
      end else if (run) begin
        if (cw.wr_integ) begin
          integ_q <= integ_d;
          if (integ_clip) begin
            sat_q <= 1'b1;
          end
        end
        if (cw.wr_drive && drive_clip) begin
          sat_q <= 1'b1;
        end
        if (cw.wr_last || (cw.wr_last_pre && pre_q)) begin
          last_q <= err_q;
        end
        if (cw.wr_pos) begin
          pos_q <= pos_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      err_q <= err_d;
    end
    if (run) begin
      prod_q <= prod_d;
      if (cw.wr_deriv) begin
        deriv_q <= prod_q[33:0];
      end
      case (cw.acc_op)
        ACC_LOAD: acc_q <= 54'(prod_q);
        ACC_ADD:  acc_q <= acc_q + 54'(prod_q);
        default:  acc_q <= acc_q;
      endcase
      if (cw.wr_drive) begin
        drive_q <= drive_d;
      end
    end
  end

  assign skip_o        = skip_q;
  assign res_o.drive   = drive_q;
  assign res_o.pos_sum = pos_d;
  assign res_o.pos_cur = pos_q;
  assign res_o.sat     = sat_q | pos_clip;

endmodule

>>> src/gated_pid_angle_controller.sv
// Gated PID angle controller: one angle beat in, one result beat out. A beat is
// taken while the sequencer is idle; a control tick inside the gate then runs an
// eight-step microprogram over one shared 18x35 signed multiplier, whose last step
// writes the output register; a preload or out-of-gate beat jumps from the first
// step straight to the skip step. The next beat is accepted the cycle after the
// result is registered, even while that result still waits to be taken; the last
// step stalls only when the output register is still full.
module gated_pid_angle_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  gpac_pkg::in_beat_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output gpac_pkg::out_beat_t        out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gpac_pkg::AddrW-1:0] paddr,
  input  logic [gpac_pkg::DataW-1:0] pwdata,
  output logic [gpac_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import gpac_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  logic       busy_q;
  logic [3:0] step_q;
  ctl_t       cw;
  logic       stall;
  logic       in_acc;
  logic       fin;
  logic       skip;
  dp_ctl_t    dp_ctl;
  dp_res_t    res;

  logic       out_valid_q;
  out_beat_t  out_q;
  out_beat_t  out_d;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop    <= RST_GAIN_PROP;
      cfg_q.gain_integ   <= RST_GAIN_INTEG;
      cfg_q.gain_deriv   <= RST_GAIN_DERIV;
      cfg_q.target_angle <= RST_TARGET_ANGLE;
      cfg_q.step_time    <= RST_STEP_TIME;
      cfg_q.step_rate    <= RST_STEP_RATE;
      cfg_q.gate_limit   <= RST_GATE_LIMIT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GAIN_PROP:    cfg_q.gain_prop    <= pwdata[15:0];
        REG_GAIN_INTEG:   cfg_q.gain_integ   <= pwdata[15:0];
        REG_GAIN_DERIV:   cfg_q.gain_deriv   <= pwdata[15:0];
        REG_TARGET_ANGLE: cfg_q.target_angle <= pwdata[14:0];
        REG_STEP_TIME:    cfg_q.step_time    <= pwdata[15:0];
        REG_STEP_RATE:    cfg_q.step_rate    <= pwdata[15:0];
        REG_GATE_LIMIT:   cfg_q.gate_limit   <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_PROP:    prdata = {16'd0, cfg_q.gain_prop};
      REG_GAIN_INTEG:   prdata = {16'd0, cfg_q.gain_integ};
      REG_GAIN_DERIV:   prdata = {16'd0, cfg_q.gain_deriv};
      REG_TARGET_ANGLE: prdata = {17'd0, cfg_q.target_angle};
      REG_STEP_TIME:    prdata = {16'd0, cfg_q.step_time};
      REG_STEP_RATE:    prdata = {16'd0, cfg_q.step_rate};
      REG_GATE_LIMIT:   prdata = {18'd0, cfg_q.gate_limit};
      default:          prdata = '0;
    endcase
  end

  // microprogram sequencer
  assign cw         = prog_word(step_q);
  assign stall      = cw.done && out_valid_q && !out_ready_i;
  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign fin        = busy_q && cw.done && !stall;

  assign dp_ctl.load = in_acc;
  assign dp_ctl.run  = busy_q && !stall;
  assign dp_ctl.cw   = cw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= ST_IT;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      step_q <= ST_IT;
    end else if (busy_q && !stall) begin
      if (cw.done) begin
        busy_q <= 1'b0;
        step_q <= ST_IT;
      end else if (cw.jmp == JMP_SKIP && skip) begin
        step_q <= cw.target;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  gpac_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_data_i (in_data_i),
    .ctl_i     (dp_ctl),
    .skip_o    (skip),
    .res_o     (res)
  );

  // result register
  always_comb begin
    out_d.applied       = cw.applied;
    out_d.drive         = cw.applied ? res.drive : '0;
    out_d.cart_position = cw.applied ? res.pos_sum : res.pos_cur;
    out_d.saturated     = cw.applied && res.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/gpac_chk.sv
// port-level checker for the gated pid angle controller, with its bind
`include "gated_pid_angle_controller_macros.svh"

module gpac_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input gpac_pkg::out_beat_t out_data_o
);
  import gpac_pkg::*;

  // one beat in flight at a time
  `GPAC_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "beat accepted while busy")

  // a result that was not applied carries no drive and no clip flag
  `GPAC_ASSERT_NOW(a_idle_result, out_valid_o && !out_data_o.applied, out_data_o.drive == '0 && !out_data_o.saturated, "unapplied result has drive or flag")

  // a waiting result holds
  `GPAC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

bind gated_pid_angle_controller gpac_chk u_chk (.*);
